// ===== hdl/csu_pkg.sv =====
// Shared types, constants and helper functions for the save-under cursor engine.
`default_nettype none

package csu_pkg;

  localparam int SPRITE_WIDTH  = 16;
  localparam int SPRITE_HEIGHT = 16;
  localparam int CELLS         = SPRITE_WIDTH * SPRITE_HEIGHT;

  localparam int POS_W   = 13;
  localparam int FX_W    = POS_W + 1;
  localparam int IDX_W   = $clog2(CELLS);
  localparam int CNT_W   = IDX_W + 1;
  localparam int COL_W   = $clog2(SPRITE_WIDTH);
  localparam int ROW_W   = $clog2(SPRITE_HEIGHT);
  localparam int PIX_W   = 32;
  localparam int CFG_IDX_W = 3;

  localparam int OUT_DEPTH_DEF = 4;

  localparam logic [PIX_W-1:0] PIXEL_WHITE = 32'hFFFF_FFFF;
  localparam logic [PIX_W-1:0] PIXEL_BLACK = 32'h0000_0000;

  // Action codes
  localparam logic [1:0] ACT_MOVE = 2'd0;
  localparam logic [1:0] ACT_STEP = 2'd1;
  localparam logic [1:0] ACT_HIDE = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_RECT  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_SKIP  = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FB_BASE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FB_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FB_HEIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BPP        = 3'd4;

  // Arrow sprite, leftmost column in bit 15
  localparam logic [SPRITE_WIDTH-1:0] SPRITE_ROWS [SPRITE_HEIGHT] = '{
    16'h0000, 16'h0080, 16'h01C0, 16'h03E0, 16'h07F0, 16'h0FF8, 16'h1FFC, 16'h3FFE,
    16'h7FFF, 16'h3FFE, 16'h1FFC, 16'h0FF8, 16'h07F0, 16'h03E0, 16'h01C0, 16'h0080
  };

  typedef struct packed {
    logic [1:0]       kind;
    logic [POS_W-1:0] rect_x;
    logic [POS_W-1:0] rect_y;
    logic [31:0]      write_address;
    logic [PIX_W-1:0] write_data;
    logic             read_valid;
    logic [31:0]      read_address;
    logic             sequence_done;
    logic             last;
  } result_t;

  // Item held between the state update and the address arithmetic
  typedef struct packed {
    logic             dual;
    logic [1:0]       kind;
    logic [POS_W-1:0] rect_x;
    logic [POS_W-1:0] rect_y;
    logic [POS_W-1:0] old_rx;
    logic [POS_W-1:0] old_ry;
    logic             w_on;
    logic [FX_W-1:0]  wfx;
    logic [FX_W-1:0]  wfy;
    logic [PIX_W-1:0] wd;
    logic             rv;
    logic [FX_W-1:0]  rfx;
    logic [FX_W-1:0]  rfy;
    logic             done;
  } stage_t;

  function automatic logic sprite_bit(input logic [ROW_W-1:0] row,
                                      input logic [COL_W-1:0] col);
    return SPRITE_ROWS[row][~col];
  endfunction

  function automatic logic on_screen(input logic [FX_W-1:0] fx, input logic [FX_W-1:0] fy,
                                     input logic [POS_W-1:0] w, input logic [POS_W-1:0] h);
    return !fx[FX_W-1] && (fx[POS_W-1:0] < w) && !fy[FX_W-1] && (fy[POS_W-1:0] < h);
  endfunction

  // base + fy*pitch + fx*stride, modulo 2^32, with signed coordinates
  function automatic logic [31:0] pixel_addr(input logic [31:0] base,
                                             input logic [15:0] pitch,
                                             input logic [2:0]  bpp,
                                             input logic signed [FX_W-1:0] fx,
                                             input logic signed [FX_W-1:0] fy);
    logic signed [30:0] row_off;
    logic signed [17:0] col_off;
    row_off = 31'(fy) * 31'($signed({1'b0, pitch}));
    col_off = 18'(fx) * 18'($signed({1'b0, bpp}));
    return base + {{1{row_off[30]}}, row_off} + {{14{col_off[17]}}, col_off};
  endfunction

endpackage

`default_nettype wire

// ===== hdl/csu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module csu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hdl/cursor_save_under_engine_top.sv =====
// Save-under cursor engine: move, walk, restore and draw a 16x16 sprite.
//
// Input channel (in_valid/in_stall) carries actions: move, step or hide.
// A move while idle gives one dirty rectangle, or two when the cursor is
// shown (old place first). Each step then handles one sprite cell: the 256
// restore cells at the old place (when shown), then the 256 draw cells at
// the new place. The step carries the framebuffer word named by the
// read_address of the previous result; draw cells keep it in the save RAM.
// Result channel (out_valid/out_stall) gives one result per item, two for a
// move over a shown cursor; out_last marks the final one.
// A result passes through the state update stage, the address multiply-add
// stage and then the output queue before it is offered.
// Throughput: one item per cycle while in_stall is low. The output queue
// holds OUT_DEPTH results, and in_stall rises when the queue and the items
// in flight leave no room for two more results.
// While out_stall holds the queue fills and the input stalls behind it.
// Reset (synchronous, rst_n low): registers take their defaults, the cursor
// is hidden and idle. The save RAM is not cleared; each entry is restored
// only after a draw wrote it. Write registers only while idle.
`default_nettype none

module cursor_save_under_engine_top #(
  parameter int OUT_DEPTH = csu_pkg::OUT_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [csu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [31:0]                     cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      in_action,
  input  wire logic signed [csu_pkg::POS_W-1:0] in_pos_x,
  input  wire logic signed [csu_pkg::POS_W-1:0] in_pos_y,
  input  wire logic [csu_pkg::PIX_W-1:0]       in_fb_pixel,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [1:0]                           out_kind,
  output logic signed [csu_pkg::POS_W-1:0]     out_rect_x,
  output logic signed [csu_pkg::POS_W-1:0]     out_rect_y,
  output logic [31:0]                          out_write_address,
  output logic [csu_pkg::PIX_W-1:0]            out_write_data,
  output logic                                 out_read_valid,
  output logic [31:0]                          out_read_address,
  output logic                                 out_sequence_done,
  output logic                                 out_last
);

  import csu_pkg::*;

  localparam int PTR_W  = $clog2(OUT_DEPTH);
  localparam int CNT_QW = $clog2(OUT_DEPTH + 1);
  localparam logic [CNT_QW:0] ROOM_LIMIT = (CNT_QW + 1)'(OUT_DEPTH - 2);
  localparam logic [CNT_W-1:0] FIRST_DRAW = CNT_W'(CELLS);
  localparam logic [CNT_W-1:0] LAST_CELL  = CNT_W'(2 * CELLS - 1);

  // Configuration registers
  logic [31:0]      fb_base_r;
  logic [POS_W-1:0] fb_width_r;
  logic [POS_W-1:0] fb_height_r;
  logic [15:0]      line_pitch_r;
  logic [2:0]       bpp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_base_r    <= '0;
      fb_width_r   <= '0;
      fb_height_r  <= '0;
      line_pitch_r <= '0;
      bpp_r        <= 3'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FB_BASE:    fb_base_r    <= cfg_wdata;
        REG_FB_WIDTH:   fb_width_r   <= cfg_wdata[POS_W-1:0];
        REG_FB_HEIGHT:  fb_height_r  <= cfg_wdata[POS_W-1:0];
        REG_LINE_PITCH: line_pitch_r <= cfg_wdata[15:0];
        REG_BPP:        bpp_r        <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // Cursor state
  logic             shown_r, shown_nxt;
  logic             busy_r, busy_nxt;
  logic [POS_W-1:0] old_x_r, old_x_nxt;
  logic [POS_W-1:0] old_y_r, old_y_nxt;
  logic [POS_W-1:0] new_x_r, new_x_nxt;
  logic [POS_W-1:0] new_y_r, new_y_nxt;
  logic [CNT_W-1:0] cell_cnt_r, cell_cnt_nxt;

  logic in_xfer;
  logic is_move, is_step, is_hide;

  logic             cur_draw, cur_on, cur_last;
  logic [IDX_W-1:0] cur_idx;
  logic [POS_W-1:0] cur_bx, cur_by;
  logic [FX_W-1:0]  cur_fx, cur_fy;
  logic [PIX_W-1:0] cell_wd;

  logic [CNT_W-1:0] rd_cnt;
  logic [POS_W-1:0] rd_bx, rd_by;
  logic [FX_W-1:0]  rd_fx, rd_fy;
  logic             rd_on;

  logic [PIX_W-1:0] save_rdata;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;

  stage_t sa_r, sa_nxt;
  logic   sa_vld_r;

  assign in_xfer = in_valid && !in_stall;
  assign is_move = (in_action == ACT_MOVE) && !busy_r;
  assign is_step = (in_action == ACT_STEP) && busy_r;
  assign is_hide = (in_action == ACT_HIDE) && !busy_r;

  // Current cell
  assign cur_draw = cell_cnt_r[IDX_W];
  assign cur_idx  = cell_cnt_r[IDX_W-1:0];
  assign cur_last = (cell_cnt_r == LAST_CELL);
  assign cur_bx   = cur_draw ? new_x_r : old_x_r;
  assign cur_by   = cur_draw ? new_y_r : old_y_r;
  assign cur_fx   = {cur_bx[POS_W-1], cur_bx} + FX_W'(cur_idx[COL_W-1:0]);
  assign cur_fy   = {cur_by[POS_W-1], cur_by} + FX_W'(cur_idx[IDX_W-1:COL_W]);
  assign cur_on   = on_screen(cur_fx, cur_fy, fb_width_r, fb_height_r);

  // Restore cells take the prefetched save entry, draw cells the sprite colour
  assign cell_wd = !cur_draw ? save_rdata :
                   sprite_bit(cur_idx[IDX_W-1:COL_W], cur_idx[COL_W-1:0]) ? PIXEL_WHITE
                                                                            : PIXEL_BLACK;

  // Cell whose pixel the next step must carry; only draw cells ask
  assign rd_cnt = is_move ? (shown_r ? '0 : FIRST_DRAW) : cell_cnt_r + 1'b1;
  assign rd_bx  = is_move ? in_pos_x : new_x_r;
  assign rd_by  = is_move ? in_pos_y : new_y_r;
  assign rd_fx  = {rd_bx[POS_W-1], rd_bx} + FX_W'(rd_cnt[COL_W-1:0]);
  assign rd_fy  = {rd_by[POS_W-1], rd_by} + FX_W'(rd_cnt[IDX_W-1:COL_W]);
  assign rd_on  = on_screen(rd_fx, rd_fy, fb_width_r, fb_height_r);

  always_comb begin
    shown_nxt    = shown_r;
    busy_nxt     = busy_r;
    old_x_nxt    = old_x_r;
    old_y_nxt    = old_y_r;
    new_x_nxt    = new_x_r;
    new_y_nxt    = new_y_r;
    cell_cnt_nxt = cell_cnt_r;
    if (in_xfer) begin
      if (is_move) begin
        new_x_nxt    = in_pos_x;
        new_y_nxt    = in_pos_y;
        cell_cnt_nxt = shown_r ? '0 : FIRST_DRAW;
        busy_nxt     = 1'b1;
      end else if (is_step) begin
        if (cur_last) begin
          busy_nxt     = 1'b0;
          shown_nxt    = 1'b1;
          old_x_nxt    = new_x_r;
          old_y_nxt    = new_y_r;
          cell_cnt_nxt = '0;
        end else begin
          cell_cnt_nxt = cell_cnt_r + 1'b1;
        end
      end else if (is_hide) begin
        shown_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shown_r    <= 1'b0;
      busy_r     <= 1'b0;
      old_x_r    <= '1;
      old_y_r    <= '1;
      new_x_r    <= '0;
      new_y_r    <= '0;
      cell_cnt_r <= '0;
    end else begin
      shown_r    <= shown_nxt;
      busy_r     <= busy_nxt;
      old_x_r    <= old_x_nxt;
      old_y_r    <= old_y_nxt;
      new_x_r    <= new_x_nxt;
      new_y_r    <= new_y_nxt;
      cell_cnt_r <= cell_cnt_nxt;
    end
  end

  // Save RAM: read ahead at the next counter value so data matches the cell
  assign ram_we    = in_xfer && is_step && cur_draw && cur_on;
  assign ram_waddr = cur_idx;
  assign ram_raddr = cell_cnt_nxt[IDX_W-1:0];

  csu_ram #(
    .WIDTH (PIX_W),
    .DEPTH (CELLS)
  ) u_save_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_fb_pixel),
    .raddr (ram_raddr),
    .rdata (save_rdata)
  );

  always_comb begin
    sa_nxt        = '0;
    sa_nxt.dual   = is_move && shown_r;
    sa_nxt.old_rx = old_x_r;
    sa_nxt.old_ry = old_y_r;
    sa_nxt.wfx    = cur_fx;
    sa_nxt.wfy    = cur_fy;
    sa_nxt.rfx    = rd_fx;
    sa_nxt.rfy    = rd_fy;
    if (is_move) begin
      sa_nxt.kind   = KIND_RECT;
      sa_nxt.rect_x = in_pos_x;
      sa_nxt.rect_y = in_pos_y;
      sa_nxt.rv     = rd_cnt[IDX_W] && rd_on;
    end else if (is_step) begin
      sa_nxt.kind = cur_on ? KIND_WRITE : KIND_SKIP;
      sa_nxt.w_on = cur_on;
      sa_nxt.wd   = cur_on ? cell_wd : '0;
      sa_nxt.rv   = !cur_last && rd_cnt[IDX_W] && rd_on;
      sa_nxt.done = cur_last;
    end else begin
      sa_nxt.kind = KIND_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_vld_r <= 1'b0;
    end else begin
      sa_vld_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sa_r <= sa_nxt;
    end
  end

  // Address stage: one multiply-add per address
  result_t res_main, res_old, q_first;

  always_comb begin
    res_main.kind          = sa_r.kind;
    res_main.rect_x        = sa_r.rect_x;
    res_main.rect_y        = sa_r.rect_y;
    res_main.write_address = sa_r.w_on ? pixel_addr(fb_base_r, line_pitch_r, bpp_r,
                                                    $signed(sa_r.wfx), $signed(sa_r.wfy))
                                       : '0;
    res_main.write_data    = sa_r.wd;
    res_main.read_valid    = sa_r.rv;
    res_main.read_address  = sa_r.rv ? pixel_addr(fb_base_r, line_pitch_r, bpp_r,
                                                  $signed(sa_r.rfx), $signed(sa_r.rfy))
                                     : '0;
    res_main.sequence_done = sa_r.done;
    res_main.last          = 1'b1;

    res_old               = '0;
    res_old.kind          = KIND_RECT;
    res_old.rect_x        = sa_r.old_rx;
    res_old.rect_y        = sa_r.old_ry;

    q_first = sa_r.dual ? res_old : res_main;
  end

  // Output queue
  result_t             q_r [OUT_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt, wr_ptr_p1;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0]   cnt_r, cnt_nxt;
  logic [CNT_QW-1:0]   push_n;
  logic [CNT_QW:0]     occupied;
  logic                pop;
  result_t             q_head;

  assign push_n    = sa_vld_r ? (sa_r.dual ? CNT_QW'(2) : CNT_QW'(1)) : '0;
  assign pop       = out_valid && !out_stall;
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;
  assign wr_ptr_nxt = wr_ptr_r + push_n[PTR_W-1:0];
  assign rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
  assign cnt_nxt    = cnt_r + push_n - CNT_QW'(pop);

  // Count results queued and in flight; hold the input when two more won't fit
  assign occupied = (CNT_QW + 1)'(cnt_r) + (CNT_QW + 1)'(push_n);
  assign in_stall = occupied > ROOM_LIMIT;

  always_ff @(posedge clk) begin
    if (sa_vld_r) begin
      q_r[wr_ptr_r] <= q_first;
    end
    if (sa_vld_r && sa_r.dual) begin
      q_r[wr_ptr_p1] <= res_main;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign q_head            = q_r[rd_ptr_r];
  assign out_valid         = (cnt_r != '0);
  assign out_kind          = q_head.kind;
  assign out_rect_x        = $signed(q_head.rect_x);
  assign out_rect_y        = $signed(q_head.rect_y);
  assign out_write_address = q_head.write_address;
  assign out_write_data    = q_head.write_data;
  assign out_read_valid    = q_head.read_valid;
  assign out_read_address  = q_head.read_address;
  assign out_sequence_done = q_head.sequence_done;
  assign out_last          = q_head.last;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_QW'(OUT_DEPTH))
    else $error("output queue overflow");

  a_idle_counter: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> cell_cnt_r == '0)
    else $error("cell counter not cleared while idle");

  a_ram_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ram_waddr != ram_raddr)
    else $error("save RAM read and write hit the same entry");

  a_done_ends_draw: assert property (@(posedge clk) disable iff (!rst_n)
    sa_vld_r && sa_r.done |-> !busy_r && shown_r)
    else $error("finished draw left the engine busy or hidden");

  a_read_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_valid |-> out_last)
    else $error("read request on a result that is not the last");

endmodule

`default_nettype wire

// ===== test/tb_cursor_save_under_engine_top.sv =====
// Self-checking testbench for the save-under cursor engine: random move/step/hide traffic.
module tb_cursor_save_under_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  import csu_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int WALK_CELLS = 2 * CELLS;

  // Arrow bitmap, leftmost column in bit 15
  localparam logic [15:0] ARROW_MASK [SPRITE_HEIGHT] = '{
    16'h0000, 16'h0080, 16'h01C0, 16'h03E0, 16'h07F0, 16'h0FF8, 16'h1FFC, 16'h3FFE,
    16'h7FFF, 16'h3FFE, 16'h1FFC, 16'h0FF8, 16'h07F0, 16'h03E0, 16'h01C0, 16'h0080
  };

  typedef struct {
    logic [1:0]               action;
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
    logic [PIX_W-1:0]         pixel;
  } cursor_req_t;

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [31:0]              cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               in_action = '0;
  logic signed [POS_W-1:0]  in_pos_x = '0;
  logic signed [POS_W-1:0]  in_pos_y = '0;
  logic [PIX_W-1:0]         in_fb_pixel = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [1:0]               out_kind;
  logic signed [POS_W-1:0]  out_rect_x;
  logic signed [POS_W-1:0]  out_rect_y;
  logic [31:0]              out_write_address;
  logic [PIX_W-1:0]         out_write_data;
  logic                     out_read_valid;
  logic [31:0]              out_read_address;
  logic                     out_sequence_done;
  logic                     out_last;

  cursor_save_under_engine_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_fb_pixel       (in_fb_pixel),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_rect_x        (out_rect_x),
    .out_rect_y        (out_rect_y),
    .out_write_address (out_write_address),
    .out_write_data    (out_write_data),
    .out_read_valid    (out_read_valid),
    .out_read_address  (out_read_address),
    .out_sequence_done (out_sequence_done),
    .out_last          (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Engine shadow: register file and cursor state
  logic [31:0]      reg_base = '0;
  logic [POS_W-1:0] reg_width = '0;
  logic [POS_W-1:0] reg_height = '0;
  logic [15:0]      reg_pitch = '0;
  logic [2:0]       reg_bpp = 3'd4;
  bit               cursor_on = 1'b0;
  bit               engine_busy = 1'b0;
  int               prev_col = -1;
  int               prev_row = -1;
  int               next_col = 0;
  int               next_row = 0;
  int unsigned      walk_pos = 0;
  logic [PIX_W-1:0] under_pix [CELLS];

  result_t          cursor_results [$];
  cursor_req_t      cmd_queue [$];

  int queued_total = 0;
  int in_accepted = 0;
  int out_accepted = 0;
  int mismatches = 0;
  int draws_done = 0;
  int settings = 0;

  // Stimulus-side view of the walk, to build well-formed sequences
  bit gen_busy = 1'b0;
  bit gen_shown = 1'b0;
  int gen_left = 0;

  bit hold_long = 1'b0;

  function automatic bit in_frame(input int fx, input int fy);
    return fx >= 0 && fx < int'(reg_width) && fy >= 0 && fy < int'(reg_height);
  endfunction

  function automatic logic [31:0] frame_addr(input int fx, input int fy);
    return reg_base + 32'(fy * int'(reg_pitch)) + 32'(fx * int'(reg_bpp));
  endfunction

  function automatic void cell_origin(input int unsigned c, output bit draw, output int idx,
                                      output int fx, output int fy);
    draw = c >= CELLS;
    idx = c % CELLS;
    fx = (draw ? next_col : prev_col) + idx % SPRITE_WIDTH;
    fy = (draw ? next_row : prev_row) + idx / SPRITE_WIDTH;
  endfunction

  // Fetch request for the cell about to be walked: on-screen draw cells only
  function automatic void fetch_for(input int unsigned c, output bit rv, output logic [31:0] ra);
    bit draw;
    int idx, fx, fy;
    rv = 1'b0;
    ra = '0;
    if (c < WALK_CELLS) begin
      cell_origin(c, draw, idx, fx, fy);
      if (draw && in_frame(fx, fy)) begin
        rv = 1'b1;
        ra = frame_addr(fx, fy);
      end
    end
  endfunction

  task automatic predict_cursor(input logic [1:0] act, input logic signed [POS_W-1:0] px,
                                input logic signed [POS_W-1:0] py, input logic [PIX_W-1:0] pix);
    result_t     r;
    bit          draw, rv;
    int          idx, fx, fy;
    int unsigned c;
    logic [31:0] ra;
    r = '0;
    if (act == ACT_MOVE && !engine_busy) begin
      next_col = px;
      next_row = py;
      walk_pos = cursor_on ? 0 : CELLS;
      engine_busy = 1'b1;
      if (cursor_on) begin
        r.kind = KIND_RECT;
        r.rect_x = POS_W'(prev_col);
        r.rect_y = POS_W'(prev_row);
        cursor_results.push_back(r);
      end
      fetch_for(walk_pos, rv, ra);
      r = '0;
      r.kind = KIND_RECT;
      r.rect_x = POS_W'(next_col);
      r.rect_y = POS_W'(next_row);
      r.read_valid = rv;
      r.read_address = ra;
    end else if (act == ACT_STEP && engine_busy) begin
      c = walk_pos % WALK_CELLS;
      cell_origin(c, draw, idx, fx, fy);
      r.kind = KIND_SKIP;
      if (in_frame(fx, fy)) begin
        r.kind = KIND_WRITE;
        r.write_address = frame_addr(fx, fy);
        if (draw) begin
          under_pix[idx] = pix;
          r.write_data = ARROW_MASK[idx / SPRITE_WIDTH][15 - idx % SPRITE_WIDTH] ?
                         PIXEL_WHITE : PIXEL_BLACK;
        end else begin
          r.write_data = under_pix[idx];
        end
      end
      if (c == WALK_CELLS - 1) begin
        r.sequence_done = 1'b1;
        engine_busy = 1'b0;
        cursor_on = 1'b1;
        prev_col = next_col;
        prev_row = next_row;
        walk_pos = 0;
        draws_done++;
      end else begin
        walk_pos = c + 1;
        fetch_for(walk_pos, rv, ra);
        r.read_valid = rv;
        r.read_address = ra;
      end
    end else begin
      if (act == ACT_HIDE && !engine_busy)
        cursor_on = 1'b0;
      r.kind = KIND_NONE;
    end
    r.last = 1'b1;
    cursor_results.push_back(r);
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h, expected %h (result %0d)",
                                what, got, want, out_accepted));
  endtask

  task automatic check_result();
    result_t want;
    if (cursor_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result, kind %0d", out_kind));
      return;
    end
    want = cursor_results.pop_front();
    compare_field("kind", out_kind, want.kind);
    compare_field("rect_x", $unsigned(out_rect_x), want.rect_x);
    compare_field("rect_y", $unsigned(out_rect_y), want.rect_y);
    compare_field("write_address", out_write_address, want.write_address);
    compare_field("write_data", out_write_data, want.write_data);
    compare_field("read_valid", out_read_valid, want.read_valid);
    compare_field("read_address", out_read_address, want.read_address);
    compare_field("sequence_done", out_sequence_done, want.sequence_done);
    compare_field("last", out_last, want.last);
  endtask

  // Monitor: results are checked before the new transfer is predicted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        check_result();
        out_accepted++;
      end
      if (in_valid && !in_stall) begin
        predict_cursor(in_action, in_pos_x, in_pos_y, in_fb_pixel);
        in_accepted++;
      end
    end
  end

  function automatic int unsigned gap_cycles(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 15);
  endfunction

  // Driver: present the next queued item once the current one has transferred
  int unsigned send_wait = 0;
  int          offered = 0;
  bit          in_quiet = 1'b0;
  cursor_req_t next_req;

  always @(negedge clk) begin
    if (!in_valid || in_accepted == offered) begin
      if (send_wait != 0 || cmd_queue.size() == 0) begin
        if (send_wait != 0)
          send_wait--;
        in_valid <= 1'b0;
      end else begin
        next_req = cmd_queue.pop_front();
        in_valid <= 1'b1;
        in_action <= next_req.action;
        in_pos_x <= next_req.x;
        in_pos_y <= next_req.y;
        in_fb_pixel <= next_req.pixel;
        offered++;
        if ($urandom_range(0, 40) == 0)
          in_quiet = !in_quiet;
        send_wait = gap_cycles(in_quiet);
      end
    end
  end

  // Receiver: random hold after each result, plus the long hold-off
  int unsigned hold_left = 0;
  int          out_seen = 0;
  bit          out_quiet = 1'b0;

  always @(negedge clk) begin
    if (out_accepted != out_seen) begin
      out_seen = out_accepted;
      if ($urandom_range(0, 40) == 0)
        out_quiet = !out_quiet;
      hold_left = gap_cycles(out_quiet);
    end
    if (hold_long || hold_left != 0) begin
      out_stall <= 1'b1;
      if (hold_left != 0)
        hold_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Starve the output for a long stretch so the engine backs up into its input
  initial begin
    while (out_accepted < 300) @(posedge clk);
    hold_long = 1'b1;
    repeat (300) @(posedge clk);
    hold_long = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("Timed out with %0d results still expected", cursor_results.size());
    $display("== FAIL ==");
    $finish;
  end

  task automatic send(input logic [1:0] act, input int x, input int y,
                      input logic [PIX_W-1:0] pix);
    cursor_req_t t;
    t.action = act;
    t.x = POS_W'(x);
    t.y = POS_W'(y);
    t.pixel = pix;
    cmd_queue.push_back(t);
    queued_total++;
    if (act == ACT_MOVE && !gen_busy) begin
      gen_busy = 1'b1;
      gen_left = gen_shown ? WALK_CELLS : CELLS;
    end else if (act == ACT_STEP && gen_busy) begin
      gen_left--;
      if (gen_left == 0) begin
        gen_busy = 1'b0;
        gen_shown = 1'b1;
      end
    end else if (act == ACT_HIDE && !gen_busy) begin
      gen_shown = 1'b0;
    end
  endtask

  function automatic int any_pos();
    return int'($urandom_range(0, 8191)) - 4096;
  endfunction

  // Cursor position biased towards the screen edges so clipping is exercised
  function automatic int pick_pos(input int span);
    int v;
    case ($urandom_range(0, 3))
      0: v = any_pos();
      1: v = int'($urandom_range(0, 32)) - 16;
      2: v = span - 16 + int'($urandom_range(0, 18));
      default: v = int'($urandom_range(0, span));
    endcase
    if (v > 4095)
      v = 4095;
    if (v < -4096)
      v = -4096;
    return v;
  endfunction

  task automatic drain();
    while (in_accepted != queued_total || cursor_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Complete any walk in progress, then wait for the engine to go quiet
  task automatic finish_walk(input bit patterned);
    while (gen_busy)
      send(ACT_STEP, any_pos(), any_pos(),
           patterned ? (gen_left[0] ? PIXEL_WHITE : PIXEL_BLACK) : $urandom());
    drain();
  endtask

  task automatic write_regs(input logic [31:0] base, input int w, input int h,
                            input int pitch, input int bpp);
    logic [CFG_IDX_W-1:0] ids [5];
    logic [31:0]          vals [5];
    ids = '{REG_FB_BASE, REG_FB_WIDTH, REG_FB_HEIGHT, REG_LINE_PITCH, REG_BPP};
    vals = '{base, w, h, pitch, bpp};
    for (int i = 0; i < 5; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= ids[i];
      cfg_wdata <= vals[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    reg_base = base;
    reg_width = POS_W'(w);
    reg_height = POS_W'(h);
    reg_pitch = 16'(pitch);
    reg_bpp = 3'(bpp);
    settings++;
  endtask

  task automatic random_items(input int n);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (gen_busy) begin
        if (r < 92)
          send(ACT_STEP, any_pos(), any_pos(), $urandom());
        else if (r < 95)
          send(ACT_MOVE, pick_pos(reg_width), pick_pos(reg_height), $urandom());
        else if (r < 98)
          send(ACT_HIDE, any_pos(), any_pos(), $urandom());
        else
          send(ACT_UNUSED, any_pos(), any_pos(), $urandom());
      end else begin
        if (r < 70)
          send(ACT_MOVE, pick_pos(reg_width), pick_pos(reg_height), $urandom());
        else if (r < 80)
          send(ACT_HIDE, any_pos(), any_pos(), $urandom());
        else if (r < 90)
          send(ACT_STEP, any_pos(), any_pos(), $urandom());
        else
          send(ACT_UNUSED, any_pos(), any_pos(), $urandom());
      end
    end
  endtask

  task automatic run_phase(input logic [31:0] base, input int w, input int h,
                           input int pitch, input int bpp, input int n);
    bit clip_moved;
    clip_moved = POS_W'(w) != reg_width || POS_W'(h) != reg_height;
    write_regs(base, w, h, pitch, bpp);
    // Hide first so no restore reaches cells that were clipped when drawn
    if (clip_moved)
      send(ACT_HIDE, 0, 0, '0);
    random_items(n);
    finish_walk(1'b0);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Base near the top of the address space so pixel addresses wrap
    write_regs(32'hFFFF_FF00, 640, 480, 65535, 7);
    // Idle corner cases, then a walk clipped at the top left
    send(ACT_STEP, 0, 0, PIXEL_WHITE);
    send(ACT_HIDE, 4095, -4096, PIXEL_BLACK);
    send(ACT_UNUSED, -1, -1, PIXEL_WHITE);
    send(ACT_MOVE, -8, -8, PIXEL_BLACK);
    send(ACT_MOVE, 4095, 4095, PIXEL_WHITE);
    send(ACT_HIDE, 0, 0, PIXEL_BLACK);
    send(ACT_UNUSED, -4096, 4095, PIXEL_BLACK);
    finish_walk(1'b1);
    // Restore the old place, draw clipped at the bottom right
    send(ACT_MOVE, 630, 470, '0);
    finish_walk(1'b1);

    run_phase($urandom(), $urandom_range(16, 4096), $urandom_range(16, 4096),
              $urandom_range(0, 65535), $urandom_range(0, 7), 150);

    repeat (20) @(negedge clk);
    $display("Covered %0d input transfers and %0d results: %0d complete draws",
             in_accepted, out_accepted, draws_done);
    $display("across %0d register settings, %0d mismatches", settings, mismatches);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
